// ===== hw/rtl/bfa_pkg.sv =====
package bfa_pkg;

  localparam int unsigned LEN_W  = 17;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADSIZE = 3'd4;

  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  localparam logic [LEN_W-1:0] POOL_SIZE_RESET = 17'h10000;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_FREE   = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

endpackage

// ===== hw/rtl/best_fit_block_allocator_core.sv =====
// Best-fit allocator over a table of free blocks (offset, length) with no coalescing.
// Input channel: in_valid_i / in_stall_o carries cmd_i, req_size_i, block_addr_i and
// block_size_i; a beat is taken when valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i carries status_o, grant_addr_o, grant_size_o, used_bytes_o,
// exactly one result beat per input beat, in order.
// Configuration: cfg_valid_i / cfg_ready_o writes pool_base (index 0) or pool_size (index 1);
// ready is always high. The user makes writes only while idle; the block does not enforce it.
// Sequence: a taken allocate beat is followed by the best-fit search through the table
// memory (one read port, one entry per cycle), a decide step and the loading of the
// result. When a removed entry forces the k entries behind it to move down (k is at most
// count - 1), a shift step copies them before the result is loaded. A free passes a check
// step before its result is loaded; a restart, no-op or zero-size allocate goes straight
// to loading its result.
// The block takes one item at a time; in_stall_o is high from the accepted beat until its
// result has been loaded into the output register. A new item may be accepted while that
// result still waits on a stalled receiver; the next result then waits until it is taken.
// Reset empties the table, clears the free-length sum, sets pool_base to 0 and pool_size to
// 65536. The table memory itself is not cleared; only entries below the live count are read.
module best_fit_block_allocator_core
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FREE_BLOCKS = 16,
  parameter int unsigned POOL_ADDR_BITS  = 16,
  parameter int unsigned HEADER_BYTES    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [LEN_W-1:0]  req_size_i,
  input  logic [ADDR_W-1:0] block_addr_i,
  input  logic [LEN_W-1:0]  block_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [ADDR_W-1:0] grant_addr_o,
  output logic [LEN_W-1:0]  grant_size_o,
  output logic [LEN_W-1:0]  used_bytes_o
);

  localparam int unsigned IW = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int unsigned SW = LEN_W + $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned WW = POOL_ADDR_BITS + LEN_W;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] pool_base_q, pool_base_d;
  logic [LEN_W-1:0]  pool_size_q, pool_size_d;
  logic [CW-1:0]     count_q, count_d;
  logic [SW-1:0]     sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic              found_q, found_d;

  logic [LEN_W-1:0]          req_q, req_d;
  logic [ADDR_W-1:0]         addr_q, addr_d;
  logic [LEN_W-1:0]          bsize_q, bsize_d;
  logic [LEN_W-1:0]          best_q, best_d;
  logic [LEN_W-1:0]          rem_q, rem_d;
  logic [IW-1:0]             pick_q, pick_d;
  logic [POOL_ADDR_BITS-1:0] pick_off_q, pick_off_d;
  logic [STAT_W-1:0]         res_status_q, res_status_d;
  logic [ADDR_W-1:0]         res_addr_q, res_addr_d;
  logic [LEN_W-1:0]          res_size_q, res_size_d;
  logic [STAT_W-1:0]         status_q, status_d;
  logic [ADDR_W-1:0]         grant_addr_q, grant_addr_d;
  logic [LEN_W-1:0]          grant_size_q, grant_size_d;
  logic [LEN_W-1:0]          used_q, used_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  logic [LEN_W-1:0]          rd_len;
  logic [POOL_ADDR_BITS-1:0] rd_off;
  logic [LEN_W:0]            fit_diff;
  logic [ADDR_W:0]           free_diff;
  logic                      in_acc, out_take, issue;

  bfa_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_FREE_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries are stored in reverse list order: physical slot 0 is the tail, so a free
  // appends at slot count and ties in the search go to the highest slot.
  assign rd_len   = ram_rdata[LEN_W-1:0];
  assign rd_off   = ram_rdata[WW-1:LEN_W];
  assign fit_diff = {1'b0, rd_len} - {1'b0, req_q};
  assign free_diff = {1'b0, addr_q} - {1'b0, pool_base_q};

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    issue = 1'b0;
    case (state_q)
      S_SCAN:  issue = (idx_q < count_q);
      S_SHIFT: issue = (idx_q <= count_q);
      default: issue = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    pool_base_d  = pool_base_q;
    pool_size_d  = pool_size_q;
    count_d      = count_q;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q && !out_take;
    idx_d        = idx_q;
    found_d      = found_q;
    req_d        = req_q;
    addr_d       = addr_q;
    bsize_d      = bsize_q;
    best_d       = best_q;
    rem_d        = rem_q;
    pick_d       = pick_q;
    pick_off_d   = pick_off_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_size_d   = res_size_q;
    status_d     = status_q;
    grant_addr_d = grant_addr_q;
    grant_size_d = grant_size_q;
    used_d       = used_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = issue;
    ram_raddr    = idx_q[IW-1:0];
    rd_pend_d    = issue;
    rd_idx_d     = idx_q[IW-1:0];

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POOL_BASE: pool_base_d = cfg_data_i;
        CFG_POOL_SIZE: pool_size_d = cfg_data_i[LEN_W-1:0];
        default:       pool_base_d = pool_base_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d        = req_size_i;
          addr_d       = block_addr_i;
          bsize_d      = block_size_i;
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_size_d   = '0;
          case (cmd_i)
            CMD_ALLOC: begin
              if (req_size_i == '0) begin
                res_status_d = ST_BADSIZE;
                state_d      = S_RESP;
              end else begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            CMD_FREE: state_d = S_FREE;
            CMD_RESTART: begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {{POOL_ADDR_BITS{1'b0}}, pool_size_q};
              count_d   = CW'(1);
              sum_d     = SW'(pool_size_q);
              state_d   = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_SCAN: begin
        if (rd_pend_q && !fit_diff[LEN_W] && (!found_q || rd_len <= best_q)) begin
          found_d    = 1'b1;
          best_d     = rd_len;
          rem_d      = fit_diff[LEN_W-1:0];
          pick_d     = rd_idx_q;
          pick_off_d = rd_off;
        end
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end else if (!rd_pend_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!found_q) begin
          res_status_d = ST_NOFIT;
          state_d      = S_RESP;
        end else begin
          res_addr_d = pool_base_q + ADDR_W'(pick_off_q);
          if (rem_q > LEN_W'(HEADER_BYTES)) begin
            ram_we     = 1'b1;
            ram_waddr  = pick_q;
            ram_wdata  = {pick_off_q + POOL_ADDR_BITS'(req_q), rem_q};
            res_size_d = req_q;
            sum_d      = sum_q - SW'(req_q);
            state_d    = S_RESP;
          end else begin
            // Whole block granted: slots above the pick move down by one.
            res_size_d = best_q;
            sum_d      = sum_q - SW'(best_q);
            count_d    = count_q - CW'(1);
            idx_d      = CW'(pick_q) + CW'(1);
            state_d    = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - IW'(1);
          ram_wdata = ram_rdata;
        end
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end else if (!rd_pend_q) begin
          state_d = S_RESP;
        end
      end

      S_FREE: begin
        if (free_diff[ADDR_W] || (free_diff[ADDR_W-1:0] >= ADDR_W'(pool_size_q))) begin
          res_status_d = ST_OUTSIDE;
        end else if (bsize_q == '0) begin
          res_status_d = ST_BADSIZE;
        end else if (count_q == CW'(MAX_FREE_BLOCKS)) begin
          res_status_d = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_q[IW-1:0];
          ram_wdata = {free_diff[POOL_ADDR_BITS-1:0], bsize_q};
          count_d   = count_q + CW'(1);
          sum_d     = sum_q + SW'(bsize_q);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          status_d     = res_status_q;
          grant_addr_d = res_addr_q;
          grant_size_d = res_size_q;
          used_d       = (sum_q >= SW'(pool_size_q)) ? '0
                                                     : pool_size_q - LEN_W'(sum_q);
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_base_q <= '0;
      pool_size_q <= POOL_SIZE_RESET;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      pool_base_q <= pool_base_d;
      pool_size_q <= pool_size_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    req_q        <= req_d;
    addr_q       <= addr_d;
    bsize_q      <= bsize_d;
    best_q       <= best_d;
    rem_q        <= rem_d;
    pick_q       <= pick_d;
    pick_off_q   <= pick_off_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_size_q   <= res_size_d;
    status_q     <= status_d;
    grant_addr_q <= grant_addr_d;
    grant_size_q <= grant_size_d;
    used_q       <= used_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign grant_addr_o = grant_addr_q;
  assign grant_size_o = grant_size_q;
  assign used_bytes_o = used_q;

endmodule

// ===== hw/rtl/bfa_ram.sv =====
module bfa_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/bfa_checker.sv =====
module bfa_checker
  import bfa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input logic [STAT_W-1:0] status_i,
  input logic [ADDR_W-1:0] grant_addr_i,
  input logic [LEN_W-1:0]  grant_size_i
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(status_i)
      && $stable(grant_addr_i) && $stable(grant_size_i))
    else $error("stalled result beat changed");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input taken again right after an accepted beat");

  // A failed request grants nothing.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (grant_addr_i == '0) && (grant_size_i == '0))
    else $error("grant reported with a failing status");

  // An address is reported only together with a granted length.
  a_addr_needs_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (grant_size_i == '0) |-> (grant_addr_i == '0))
    else $error("grant address without a granted length");

endmodule

bind best_fit_block_allocator_core bfa_checker u_bfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_i     (status_o),
  .grant_addr_i (grant_addr_o),
  .grant_size_i (grant_size_o)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bfa_pkg::*;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned OFF_BITS   = 16;
  localparam int unsigned HDR_BYTES  = 32;
  localparam int unsigned WDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD  = 300;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  req_size;
    logic [ADDR_W-1:0] block_addr;
    logic [LEN_W-1:0]  block_size;
  } pool_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] grant_addr;
    logic [LEN_W-1:0]  grant_size;
    logic [LEN_W-1:0]  used_bytes;
  } pool_resp_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i  = CFG_POOL_BASE;
  logic [ADDR_W-1:0] cfg_data_i   = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  cmd_i        = CMD_NOP;
  logic [LEN_W-1:0]  req_size_i   = '0;
  logic [ADDR_W-1:0] block_addr_i = '0;
  logic [LEN_W-1:0]  block_size_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [ADDR_W-1:0] grant_addr_o;
  logic [LEN_W-1:0]  grant_size_o;
  logic [LEN_W-1:0]  used_bytes_o;

  best_fit_block_allocator_core #(
    .MAX_FREE_BLOCKS(SLOTS),
    .POOL_ADDR_BITS (OFF_BITS),
    .HEADER_BYTES   (HDR_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .req_size_i  (req_size_i),
    .block_addr_i(block_addr_i),
    .block_size_i(block_size_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .grant_addr_o(grant_addr_o),
    .grant_size_o(grant_size_o),
    .used_bytes_o(used_bytes_o)
  );

  // Shadow copy of the free list and of the pool registers.
  logic [OFF_BITS-1:0] sh_off [SLOTS];
  logic [LEN_W-1:0]    sh_len [SLOTS];
  int                  sh_cnt  = 0;
  logic [ADDR_W-1:0]   sh_base = '0;
  logic [LEN_W-1:0]    sh_size = POOL_SIZE_RESET;

  pool_cmd_t  cmd_q[$];
  pool_resp_t resp_q[$];

  int   errors     = 0;
  int   n_sent     = 0;
  int   n_checked  = 0;
  int   n_settings = 1;
  int   st_hits[5] = '{0, 0, 0, 0, 0};
  int   hold_reqs  = 0;
  logic quiet      = 1'b0;

  function automatic pool_resp_t allocator_step(input logic [CMD_W-1:0]  cmd,
                                                input logic [LEN_W-1:0]  req,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [LEN_W-1:0]  bsz);
    pool_resp_t      r;
    int              pick;
    int              sum;
    logic [LEN_W-1:0] best;
    logic [LEN_W-1:0] rem;
    logic [ADDR_W:0]  hi;
    r    = '{ST_OK, '0, '0, '0};
    pick = -1;
    best = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (req == 0) begin
          r.status = ST_BADSIZE;
        end else begin
          for (int i = 0; i < sh_cnt; i++) begin
            if (sh_len[i] >= req && (pick < 0 || sh_len[i] < best)) begin
              pick = i;
              best = sh_len[i];
            end
          end
          if (pick < 0) begin
            r.status = ST_NOFIT;
          end else begin
            r.grant_addr = sh_base + ADDR_W'(sh_off[pick]);
            rem = best - req;
            if (rem > HDR_BYTES) begin
              r.grant_size = req;
              sh_off[pick] = sh_off[pick] + req[OFF_BITS-1:0];
              sh_len[pick] = rem;
            end else begin
              // Too little left for a header, so the whole block goes out.
              r.grant_size = best;
              for (int i = pick; i < sh_cnt - 1; i++) begin
                sh_off[i] = sh_off[i+1];
                sh_len[i] = sh_len[i+1];
              end
              sh_cnt--;
            end
          end
        end
      end
      CMD_FREE: begin
        hi = {1'b0, sh_base} + (ADDR_W+1)'(sh_size);
        if (addr < sh_base || {1'b0, addr} >= hi) begin
          r.status = ST_OUTSIDE;
        end else if (bsz == 0) begin
          r.status = ST_BADSIZE;
        end else if (sh_cnt >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          for (int i = sh_cnt; i > 0; i--) begin
            sh_off[i] = sh_off[i-1];
            sh_len[i] = sh_len[i-1];
          end
          sh_off[0] = OFF_BITS'(addr - sh_base);
          sh_len[0] = bsz;
          sh_cnt++;
        end
      end
      CMD_RESTART: begin
        sh_off[0] = '0;
        sh_len[0] = sh_size;
        sh_cnt    = 1;
      end
      default: ;
    endcase
    sum = 0;
    for (int i = 0; i < sh_cnt; i++) sum += int'(sh_len[i]);
    r.used_bytes = (sum >= int'(sh_size)) ? '0 : LEN_W'(int'(sh_size) - sum);
    return r;
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Driver: a beat moves when valid is high and stall is low.
  always @(posedge clk_i) begin
    int        tx_gap;
    pool_cmd_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        resp_q.push_back(allocator_step(cmd_i, req_size_i, block_addr_i, block_size_i));
        n_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 16);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap == 0 && cmd_q.size() > 0) begin
          nxt = cmd_q.pop_front();
          cmd_i        <= nxt.cmd;
          req_size_i   <= nxt.req_size;
          block_addr_i <= nxt.block_addr;
          block_size_i <= nxt.block_size;
          in_valid_i   <= 1'b1;
        end else begin
          if (tx_gap > 0) tx_gap--;
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    int         rx_gap;
    int         hold_left;
    int         hold_seen;
    pool_resp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        if (status_o < 5) st_hits[status_o]++;
        if (resp_q.size() == 0) begin
          $error("result beat with no prediction outstanding");
          errors++;
        end else begin
          want = resp_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (grant_addr_o !== want.grant_addr) begin
            $error("grant_addr: expected %h, got %h", want.grant_addr, grant_addr_o);
            errors++;
          end
          if (grant_size_o !== want.grant_size) begin
            $error("grant_size: expected %0d, got %0d", want.grant_size, grant_size_o);
            errors++;
          end
          if (used_bytes_o !== want.used_bytes) begin
            $error("used_bytes: expected %0d, got %0d", want.used_bytes, used_bytes_o);
            errors++;
          end
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) hold_left--;
      else if (rx_gap > 0) rx_gap--;
      else if (!quiet && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 16);
      out_stall_i <= (hold_left > 0) || (rx_gap > 0);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb NOT OK");
    $finish;
  end

  task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_POOL_BASE) sh_base = data;
    else sh_size = data[LEN_W-1:0];
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_SIZE, size);
    n_settings++;
  endtask

  // Returns once every queued command has gone in and every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || resp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [LEN_W-1:0] rq,
                          input logic [ADDR_W-1:0] ad, input logic [LEN_W-1:0] bs);
    cmd_q.push_back('{c, rq, ad, bs});
  endtask

  // Mostly in-pool allocs and frees with sizes that fit; some sized to leave a
  // remainder at the header threshold, plus a share of bad sizes and stray addresses.
  task automatic gen_mix(input int n);
    int               roll;
    int               span;
    logic [CMD_W-1:0]  c;
    logic [LEN_W-1:0]  rq;
    logic [LEN_W-1:0]  bs;
    logic [LEN_W-1:0]  last_bs;
    logic [ADDR_W-1:0] ad;
    span    = int'(sh_size);
    last_bs = 17'd1;
    @(negedge clk_i);
    for (int k = 0; k < n; k++) begin
      roll = (k == 0) ? 0 : $urandom_range(0, 99);
      rq   = LEN_W'($urandom_range(0, 65536));
      bs   = LEN_W'($urandom_range(0, 65536));
      ad   = $urandom;
      if (roll < 4) begin
        c = CMD_RESTART;
      end else if (roll < 52) begin
        c    = CMD_ALLOC;
        roll = $urandom_range(0, 19);
        if (roll < 12) rq = LEN_W'($urandom_range(1, span / 8 + 1));
        else if (roll < 16) begin
          rq = (last_bs > 33) ? LEN_W'(int'(last_bs) - int'($urandom_range(0, 33)))
                              : last_bs;
        end
        else if (roll < 18) rq = LEN_W'($urandom_range(1, span));
        else if (roll == 18) rq = '0;
      end else if (roll < 94) begin
        c    = CMD_FREE;
        roll = $urandom_range(0, 19);
        if (roll < 17) ad = sh_base + ADDR_W'($urandom_range(0, span - 1));
        if (roll < 4) bs = last_bs;
        else if (roll < 16) bs = LEN_W'($urandom_range(1, span / 8 + 1));
        else if (roll == 19) bs = '0;
        last_bs = (bs == 0) ? 17'd1 : bs;
      end else begin
        c = CMD_NOP;
      end
      push_cmd(c, rq, ad, bs);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under the reset pool settings.
    @(negedge clk_i);
    push_cmd(CMD_ALLOC, 17'd100, '0, '0);                 // empty list, nothing fits
    push_cmd(CMD_NOP, 17'h1FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    push_cmd(CMD_FREE, '0, 32'h0001_0000, 17'd16);        // one past the pool end
    push_cmd(CMD_FREE, '0, 32'h0000_0000, 17'd0);         // zero-length free
    push_cmd(CMD_ALLOC, 17'd0, '0, '0);                   // zero-length allocate
    push_cmd(CMD_RESTART, '0, '0, '0);
    push_cmd(CMD_ALLOC, 17'h10000, '0, '0);               // takes the whole pool
    push_cmd(CMD_RESTART, '0, '0, '0);
    push_cmd(CMD_ALLOC, 17'd65503, '0, '0);               // split, 33 bytes left
    push_cmd(CMD_ALLOC, 17'd1, '0, '0);                   // 32 left, no split
    push_cmd(CMD_FREE, '0, 32'h0000_FFFF, 17'h10000);
    push_cmd(CMD_FREE, '0, 32'h0000_0000, 17'h10000);     // free bytes exceed the pool
    push_cmd(CMD_FREE, '0, 32'h0000_0100, 17'd64);
    push_cmd(CMD_FREE, '0, 32'h0000_0200, 17'd64);
    push_cmd(CMD_ALLOC, 17'd64, '0, '0);                  // tie goes to the head
    for (int i = 0; i < 13; i++) begin
      push_cmd(CMD_FREE, '0, ADDR_W'(i) * 32'h1000 + 32'd8, LEN_W'(100 + i));
    end
    push_cmd(CMD_FREE, '0, 32'h0000_1234, 17'd50);        // list already full
    wait_idle();

    set_pool(32'h1234_5678, 32'd4096);
    gen_mix(120);
    wait_idle();

    // Smallest pool, with its base right below the top of the address space.
    set_pool(32'hFFFF_FFF0, 32'd64);
    gen_mix(80);
    wait_idle();

    // The receiver holds off long enough for the block to back up its input.
    set_pool(32'h0000_0000, 32'd65536);
    @(negedge clk_i);
    hold_reqs++;
    gen_mix(100);
    wait_idle();

    set_pool(32'h8000_0000, 32'd1000);
    gen_mix(40);
    wait_idle();
    gen_mix(40);
    wait_idle();

    @(negedge clk_i);
    quiet = 1'b1;
    set_pool(32'h0001_0000, 32'd20000);
    gen_mix(70);
    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("%0d commands over %0d pool settings, %0d results checked, %0d mismatches.",
             n_sent, n_settings, n_checked, errors);
    $display("Statuses seen: ok %0d, no fit %0d, outside %0d, full %0d, bad size %0d.",
             st_hits[0], st_hits[1], st_hits[2], st_hits[3], st_hits[4]);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
